// ===== sv/kstg_pkg.sv =====
// Shared types and constants for the keyed sine tone generator.
`default_nettype none

package kstg_pkg;

  // Register file geometry
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned STEP_W     = 24;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_SAMPLES = 2'd0,
    REG_PHASE_STEP     = 2'd1
  } cfg_reg_e;

  localparam logic [COUNT_W-1:0] PERIOD_RST = 16'd64;
  localparam logic [STEP_W-1:0]  STEP_RST   = 24'd262144;

  // Polynomial sine coefficients, Q28
  localparam logic [28:0] SIN_A = 29'd421657428;
  localparam logic [27:0] SIN_B = 28'd172226217;
  localparam logic [24:0] SIN_C = 25'd19004244;

  typedef struct packed {
    logic [COUNT_W-1:0] period_samples;
    logic [STEP_W-1:0]  phase_step;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/kstg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module kstg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  localparam int unsigned DEPTH = 2 ** AW;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/kstg_state.sv =====
// Tone state record (count, phase, gate) held in RAM with read-modify-write and forwarding.
`default_nettype none

module kstg_state
  import kstg_pkg::*;
#(
  parameter int unsigned PHASE_BITS = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cfg_t                  cfg_i,
  input  wire logic                  acc_i,
  input  wire logic                  key_i,
  output logic      [PHASE_BITS-1:0] phase_o,
  output logic                       gate_o
);

  localparam int unsigned STATE_W = 1 + PHASE_BITS + COUNT_W;
  localparam int unsigned STATE_AW = 1;

  typedef struct packed {
    logic                  gate;
    logic [PHASE_BITS-1:0] phase;
    logic [COUNT_W-1:0]    count;
  } state_t;

  state_t rd_state;
  state_t cur;
  state_t nxt;
  state_t fwd_data_q;
  logic   fwd_q;
  logic   vld_q;

  logic [COUNT_W-1:0]    count_inc;
  logic [PHASE_BITS-1:0] phase_adv;
  logic                  period_end;

  // single record lives in row 0
  kstg_ram #(
    .WIDTH (STATE_W),
    .AW    (STATE_AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (acc_i),
    .waddr_i ('0),
    .wdata_i (nxt),
    .raddr_i ('0),
    .rdata_o (rd_state)
  );

  // RAM read data does not yet show the last write: forward the last write
  always_comb begin
    if (fwd_q) begin
      cur = fwd_data_q;
    end else if (vld_q) begin
      cur = rd_state;
    end else begin
      cur = '0;
    end
  end

  assign count_inc  = cur.count + COUNT_W'(1);
  assign phase_adv  = cur.phase + PHASE_BITS'(cfg_i.phase_step);
  assign period_end = (count_inc >= cfg_i.period_samples);

  always_comb begin
    if (period_end) begin
      nxt.gate  = key_i;
      nxt.phase = '0;
      nxt.count = '0;
    end else begin
      nxt.gate  = cur.gate;
      nxt.phase = phase_adv;
      nxt.count = count_inc;
    end
  end

  assign phase_o = phase_adv;
  assign gate_o  = cur.gate;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      fwd_q <= acc_i;
      if (acc_i) begin
        vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= nxt;
  end

  a_period_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && period_end |=> cur.count == '0 && cur.phase == '0 && cur.gate == $past(key_i))
    else $error("state not restarted at period end");

  a_gate_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && !period_end |=> cur.gate == $past(cur.gate))
    else $error("gate changed inside a period");

endmodule

`default_nettype wire

// ===== sv/kstg_sine.sv =====
// Pipelined fixed-point sine evaluation with per-stage flow control.
`default_nettype none

module kstg_sine
  import kstg_pkg::*;
#(
  parameter int unsigned PHASE_BITS  = 24,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic        [PHASE_BITS-1:0]  phase_i,
  input  wire logic                          gate_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed      [SAMPLE_BITS-1:0] sample_o,
  output logic                               gate_o
);

  localparam int unsigned NST    = 7;
  localparam int unsigned PROD_W = 30 + SAMPLE_BITS - 1;
  localparam int unsigned MAG_W  = PROD_W + 1 - 28;
  localparam logic [SAMPLE_BITS-2:0] AMP = '1;
  localparam logic [PROD_W:0]        RND = (PROD_W + 1)'(1) << 27;

  logic [NST:1]   vld_q;
  logic [NST:1]   vld_d;
  logic [NST:1]   vld_prev;
  logic [NST+1:1] rdy;
  logic [NST:1]   gt_q;

  logic [PHASE_BITS-1:0]  ph1_q;
  logic [1:0]             quad2_q, quad3_q, quad4_q, quad5_q, quad6_q;
  logic [16:0]            z2_q, z3_q, z4_q;
  logic [16:0]            zz2_q, zz3_q;
  logic [27:0]            u3_q;
  logic [28:0]            v4_q;
  logic [29:0]            s5_q;
  logic [PROD_W-1:0]      prod6_q;
  logic [SAMPLE_BITS-1:0] smp7_q;

  // stage 1 -> 2: quadrant, mirrored z, z^2
  logic [31:0] p32;
  logic [15:0] z16;
  logic [16:0] z_c;
  logic [33:0] zz_full;
  assign p32     = 32'(ph1_q) << (32 - PHASE_BITS);
  assign z16     = p32[29:14];
  assign z_c     = p32[30] ? (17'h10000 - {1'b0, z16}) : {1'b0, z16};
  assign zz_full = 34'(z_c) * 34'(z_c);

  // stage 2 -> 3
  logic [41:0] cz;
  logic [27:0] u_c;
  assign cz  = 42'(SIN_C) * 42'(zz2_q);
  assign u_c = SIN_B - 28'(cz[41:16]);

  // stage 3 -> 4
  logic [44:0] uz;
  logic [28:0] v_c;
  assign uz  = 45'(u3_q) * 45'(zz3_q);
  assign v_c = SIN_A - uz[44:16];

  // stage 4 -> 5
  logic [45:0] vz;
  assign vz = 46'(v4_q) * 46'(z4_q);

  // stage 5 -> 6
  logic [PROD_W-1:0] prod_c;
  assign prod_c = PROD_W'(s5_q) * PROD_W'(AMP);

  // stage 6 -> 7: round, clamp, sign, gate
  logic [PROD_W:0]        rnd;
  logic [MAG_W-1:0]       mag_w;
  logic [SAMPLE_BITS-2:0] mag;
  logic [SAMPLE_BITS-1:0] pos;
  logic [SAMPLE_BITS-1:0] smp_c;
  assign rnd   = (PROD_W + 1)'(prod6_q) + RND;
  assign mag_w = rnd[PROD_W:28];
  assign mag   = (mag_w > MAG_W'(AMP)) ? AMP : mag_w[SAMPLE_BITS-2:0];
  assign pos   = {1'b0, mag};
  always_comb begin
    if (!gt_q[6]) begin
      smp_c = '0;
    end else if (quad6_q[1]) begin
      smp_c = ~pos + SAMPLE_BITS'(1);
    end else begin
      smp_c = pos;
    end
  end

  // flow control: a stage advances when it is empty or its successor moves
  always_comb begin
    rdy[NST+1] = out_ready_i;
    for (int k = NST; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign vld_prev = {vld_q[NST-1:1], in_valid_i};

  always_comb begin
    for (int k = 1; k <= NST; k++) begin
      vld_d[k] = rdy[k] ? vld_prev[k] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      ph1_q   <= phase_i;
      gt_q[1] <= gate_i;
    end
    if (rdy[2]) begin
      quad2_q <= p32[31:30];
      z2_q    <= z_c;
      zz2_q   <= zz_full[32:16];
      gt_q[2] <= gt_q[1];
    end
    if (rdy[3]) begin
      quad3_q <= quad2_q;
      z3_q    <= z2_q;
      zz3_q   <= zz2_q;
      u3_q    <= u_c;
      gt_q[3] <= gt_q[2];
    end
    if (rdy[4]) begin
      quad4_q <= quad3_q;
      z4_q    <= z3_q;
      v4_q    <= v_c;
      gt_q[4] <= gt_q[3];
    end
    if (rdy[5]) begin
      quad5_q <= quad4_q;
      s5_q    <= vz[45:16];
      gt_q[5] <= gt_q[4];
    end
    if (rdy[6]) begin
      quad6_q <= quad5_q;
      prod6_q <= prod_c;
      gt_q[6] <= gt_q[5];
    end
    if (rdy[7]) begin
      smp7_q  <= smp_c;
      gt_q[7] <= gt_q[6];
    end
  end

  assign in_ready_o  = rdy[1];
  assign out_valid_o = vld_q[NST];
  assign sample_o    = $signed(smp7_q);
  assign gate_o      = gt_q[NST];

  a_z_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> z2_q <= 17'h10000 && zz2_q <= z2_q)
    else $error("quadrant argument out of range");

  a_no_min_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NST] |-> smp7_q != {1'b1, {(SAMPLE_BITS-1){1'b0}}})
    else $error("sample hit the most negative code");

endmodule

`default_nettype wire

// ===== sv/keyed_sine_tone_generator_unit.sv =====
// Top level of the keyed sine tone generator: config registers, state unit, sine pipeline.
`default_nettype none

// Channel    Dir  Handshake             Payload
// s_axis     in   tvalid / tready       tdata[0] key_down
// m_axis     out  tvalid / tready       tdata sample (Q1.15), tuser[0] gate_open
// cfg        in   cfg_we_i (no wait)    cfg_idx_i register index, cfg_wdata_i value
//
// One sample per clock sustained while m_axis accepts. The state read-modify-write
// finishes in the accepting cycle; the sine unit has seven register stages (phase
// capture, z^2, two polynomial steps, final z product, amplitude scale,
// round/clamp) between s_axis and m_axis.
// The state record sits in row 0 of a two-row RAM; the last write is forwarded, so
// back-to-back ticks see each other's update.
// Reset: count, phase and gate clear to zero (tone off), period 64, step 2^18.
// A stall on m_axis fills pipeline bubbles first; s_axis stalls only when all
// stages hold data.

module keyed_sine_tone_generator_unit
  import kstg_pkg::*;
#(
  parameter int unsigned PHASE_BITS  = 24,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input ticks
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [7:0]                      s_axis_tdata_i,   // [0] key_down
  // output samples
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata_o,   // [SAMPLE_BITS-1:0] sample
  output logic [0:0]                           m_axis_tuser_o,   // [0] gate_open
  // configuration writes
  input  wire logic                            cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]            cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]           cfg_wdata_i
);

  localparam int unsigned TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  cfg_t cfg_q;
  logic acc;
  logic [PHASE_BITS-1:0] tick_phase;
  logic tick_gate;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic gate_open;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_samples <= PERIOD_RST;
      cfg_q.phase_step     <= STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PERIOD_SAMPLES: cfg_q.period_samples <= cfg_wdata_i[COUNT_W-1:0];
        REG_PHASE_STEP:     cfg_q.phase_step     <= cfg_wdata_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign acc = s_axis_tvalid_i && s_axis_tready_o;

  // per-tick count/phase/gate update
  kstg_state #(
    .PHASE_BITS (PHASE_BITS)
  ) u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .acc_i   (acc),
    .key_i   (s_axis_tdata_i[0]),
    .phase_o (tick_phase),
    .gate_o  (tick_gate)
  );

  // sine of the advanced phase under the pre-update gate
  kstg_sine #(
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .phase_i     (tick_phase),
    .gate_i      (tick_gate),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sample_o    (sample),
    .gate_o      (gate_open)
  );

  assign m_axis_tdata_o = TDATA_W'($unsigned(sample));
  assign m_axis_tuser_o = gate_open;

  // an empty output register means every stage can take data
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

endmodule

`default_nettype wire

// ===== bench/keyed_sine_tone_generator_unit_tb.sv =====
// Self-checking testbench for the keyed sine tone generator: directed and random key streams.
`timescale 1ns / 1ps

module keyed_sine_tone_generator_unit_tb;
  import kstg_pkg::*;

  localparam int unsigned PHASE_W  = 24;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;

  // Register stages from input to result transaction; the drain wait pads this.
  localparam int unsigned PIPE_LATENCY = 7;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  localparam int unsigned RANDOM_SEGMENTS   = 16;
  localparam int unsigned TICKS_PER_SEGMENT = 125;

  // Register indexes with no register behind them; writes must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 2'd3;

  // Polynomial sine coefficients (Q28) and output amplitude.
  localparam longint unsigned COEF_A   = 64'd421657428;
  localparam longint unsigned COEF_B   = 64'd172226217;
  localparam longint unsigned COEF_C   = 64'd19004244;
  localparam longint unsigned TONE_AMP = (64'd1 << (SAMPLE_W - 1)) - 64'd1;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] tone_sample;
    logic                gate_open;
  } tone_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [7:0]            s_axis_tdata_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [TDATA_W-1:0]    m_axis_tdata_o;
  logic [0:0]            m_axis_tuser_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // Shadow copy of the block: config registers and tone state.
  logic [COUNT_W-1:0] period_reg;
  logic [STEP_W-1:0]  step_reg;
  logic [COUNT_W-1:0] tone_count;
  logic [PHASE_W-1:0] tone_phase;
  logic               tone_gate;

  tone_result_t expected_tones[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;
  int unsigned result_count;
  int unsigned cycle_count;

  keyed_sine_tone_generator_unit #(
    .PHASE_BITS (PHASE_W),
    .SAMPLE_BITS(SAMPLE_W)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Q1.15 sine of a 24-bit turn fraction. Quadrant from the top two phase
  // bits, odd quadrants mirror z, second half of the turn is negated.
  function automatic logic [SAMPLE_W-1:0] sine_q15(input logic [PHASE_W-1:0] phase);
    logic [1:0]      quad;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned u;
    longint unsigned v;
    longint unsigned s;
    longint unsigned mag;
    quad = phase[PHASE_W-1 -: 2];
    z    = 64'(phase[PHASE_W-3 -: 16]);
    if (quad[0]) begin
      z = 64'd65536 - z;
    end
    z2  = (z * z) >> 16;
    u   = COEF_B - ((COEF_C * z2) >> 16);
    v   = COEF_A - ((u * z2) >> 16);
    s   = (v * z) >> 16;
    mag = (s * TONE_AMP + (64'd1 << 27)) >> 28;
    if (mag > TONE_AMP) begin
      mag = TONE_AMP;
    end
    if (quad[1]) begin
      mag = -mag;
    end
    return mag[SAMPLE_W-1:0];
  endfunction

  // One sample tick: advance count and phase, emit under the old gate,
  // then on period end restart and latch the key level into the gate.
  function automatic tone_result_t predict_tone_tick(input logic key);
    tone_result_t       res;
    logic [COUNT_W-1:0] next_count;
    logic [PHASE_W-1:0] next_phase;
    next_count      = tone_count + COUNT_W'(1);
    next_phase      = tone_phase + step_reg;
    res.tone_sample = tone_gate ? sine_q15(next_phase) : '0;
    res.gate_open   = tone_gate;
    if (next_count >= period_reg) begin
      next_count = '0;
      next_phase = '0;
      tone_gate  = key;
    end
    tone_count = next_count;
    tone_phase = next_phase;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Driver side
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    error_count++;
    $display("MISMATCH @%0t result %0d: %s", $time, result_count, what);
  endtask

  task automatic set_idle_mode(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 58;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 58;
      end
      default: begin
        send_idle_pct  = 16;
        recv_stall_pct = 16;
      end
    endcase
  endtask

  // Sends one tick transaction. tvalid stays high on return so a following
  // tick can go back to back; the gap loop or the drain drops it.
  task automatic send_tick(input logic key);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'b0, key};
    @(posedge clk_i);
    while (!s_axis_tready_o) begin
      @(posedge clk_i);
    end
    expected_tones.push_back(predict_tone_tick(key));
  endtask

  // Block is idle once every expected sample came back and the pipe emptied.
  task automatic wait_for_drain();
    s_axis_tvalid_i <= 1'b0;
    while (expected_tones.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
  endtask

  // Write strobe is high for a single cycle; the wait after it keeps back-to-back writes
  // from stacking two updates of cfg_we_i in one time step.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_PERIOD_SAMPLES) begin
      period_reg = value[COUNT_W-1:0];
    end else if (idx == REG_PHASE_STEP) begin
      step_reg = value[STEP_W-1:0];
    end
  endtask

  // Key held in runs of up to a few periods, so the gate opens and closes
  // on period ends and long tone stretches sweep the sine; some one-tick
  // noise mixed in.
  task automatic run_keyed_ticks(input int unsigned n, input logic [COUNT_W-1:0] period);
    int unsigned i;
    int unsigned run_left;
    int unsigned span;
    logic        key;
    run_left = 0;
    key      = 1'b0;
    if (period < 2) begin
      span = 4;
    end else if (period > 60) begin
      span = 180;
    end else begin
      span = 3 * period;
    end
    for (i = 0; i < n; i++) begin
      if (run_left == 0) begin
        if ($urandom_range(99) < 85) begin
          key      = ~key;
          run_left = $urandom_range(span, 1);
        end else begin
          key      = 1'($urandom_range(1));
          run_left = 1;
        end
      end
      send_tick(key);
      run_left--;
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Quarter-turn step: peak, zero crossing and trough of the sine, gate
  // opening on one period end and closing on the next.
  task automatic test_quarter_turns();
    set_idle_mode(IDLE_NONE);
    wait_for_drain();
    write_register(REG_PERIOD_SAMPLES, 24'd4);
    write_register(REG_PHASE_STEP, 24'h400000);
    repeat (4) send_tick(1'b1);
    repeat (4) send_tick(1'b0);
  endtask

  // Period zero and one end on every tick; then a full-scale step that
  // wraps to just below zero phase.
  task automatic test_short_periods();
    wait_for_drain();
    write_register(REG_PERIOD_SAMPLES, 24'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    wait_for_drain();
    write_register(REG_PERIOD_SAMPLES, 24'd1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_for_drain();
    write_register(REG_PERIOD_SAMPLES, 24'd3);
    write_register(REG_PHASE_STEP, 24'hFFFFFF);
    repeat (5) send_tick(1'b1);
  endtask

  // Period lowered below the running count: next tick must end the period.
  task automatic test_period_shrink();
    wait_for_drain();
    write_register(REG_PERIOD_SAMPLES, 24'd16);
    write_register(REG_PHASE_STEP, 24'h100000);
    repeat (5) send_tick(1'b1);
    wait_for_drain();
    write_register(REG_PERIOD_SAMPLES, 24'd2);
    send_tick(1'b0);
  endtask

  // Writes to unmapped indexes must leave period and step alone.
  task automatic test_unmapped_registers();
    wait_for_drain();
    write_register(REG_UNMAPPED_A, 24'($urandom));
    write_register(REG_UNMAPPED_B, 24'hFFFFFF);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  // Random settings per segment, extremes first, idle mode rotating so
  // each handshake pattern sees four of the segments.
  task automatic test_random_tones();
    int unsigned        seg;
    logic [COUNT_W-1:0] period;
    logic [STEP_W-1:0]  step;
    for (seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      case (seg)
        0: begin
          period = 16'd2;
          step   = 24'h800000;
        end
        1: begin
          period = 16'hFFFF;
          step   = 24'hFFFFFF;
        end
        2: begin
          period = 16'd0;
          step   = 24'h000000;
        end
        3: begin
          period = 16'd1;
          step   = 24'($urandom);
        end
        default: begin
          if ($urandom_range(3) == 0) begin
            period = 16'($urandom);
          end else begin
            period = 16'($urandom_range(40, 2));
          end
          // Half the time the step matches the period, as software sets it.
          if ($urandom_range(1) == 0 && period > 1) begin
            step = 24'((32'd1 << PHASE_W) / period);
          end else begin
            step = 24'($urandom);
          end
        end
      endcase
      set_idle_mode(idle_mode_e'(seg % 4));
      wait_for_drain();
      write_register(REG_PERIOD_SAMPLES, {8'h00, period});
      write_register(REG_PHASE_STEP, step);
      run_keyed_ticks(TICKS_PER_SEGMENT, period);
    end
    wait_for_drain();
  endtask

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  // Random backpressure on the sample stream.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each sample transaction against the oldest prediction.
  always @(posedge clk_i) begin : sample_checker
    tone_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_tones.size() == 0) begin
        report_mismatch("sample transaction with nothing expected");
      end else begin
        want = expected_tones.pop_front();
        if (m_axis_tdata_o[SAMPLE_W-1:0] !== want.tone_sample) begin
          report_mismatch($sformatf("sample got %0d want %0d",
                                    $signed(m_axis_tdata_o[SAMPLE_W-1:0]),
                                    $signed(want.tone_sample)));
        end
        if (m_axis_tuser_o[0] !== want.gate_open) begin
          report_mismatch($sformatf("gate_open got %b want %b",
                                    m_axis_tuser_o[0], want.gate_open));
        end
      end
      result_count++;
    end
  end

  // Watchdog on total cycles.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_PERIOD_SAMPLES;
    cfg_wdata_i     = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    error_count     = 0;
    result_count    = 0;
    cycle_count     = 0;
    // Reset values of the shadow model.
    period_reg      = 16'd64;
    step_reg        = 24'd262144;
    tone_count      = '0;
    tone_phase      = '0;
    tone_gate       = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_quarter_turns();
    test_short_periods();
    test_period_shrink();
    test_unmapped_registers();
    test_random_tones();

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/kstg_pkg.sv
sv/kstg_ram.sv
sv/kstg_state.sv
sv/kstg_sine.sv
sv/keyed_sine_tone_generator_unit.sv
bench/keyed_sine_tone_generator_unit_tb.sv
